/* sv/bce_pkg.sv */
// bce_pkg: types, scan tables and step tables for the block coefficient encoder
// no dependencies; imported by every module of the block but bce_ram
`default_nettype none

package bce_pkg;

   localparam int COEFF_WIDTH = 20;
   localparam int LEVEL_WIDTH = 9;
   localparam int WORD_WIDTH  = 16;
   localparam int BLOCK_SIZE  = 64;
   localparam int BANKS       = 2;

   localparam logic KIND_COEFF = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic signed [COEFF_WIDTH-1:0] coefficient;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic                  last;
   } rsp_type;

   // command handed from the load side to the coding side
   typedef struct packed {
      logic       kind;
      logic       bank;
      logic       any_nz;
      logic [5:0] last_nz;
   } cmd_type;

   // log2 of the quantiser step, indexed by row + col (last entry is padding)
   localparam logic [2:0] STEP_COARSE_LOG2 [16] =
      '{3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};
   localparam logic [2:0] STEP_FINE_LOG2 [16] =
      '{3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5};

   // zigzag index -> raster position
   localparam logic [5:0] SCAN_ORDER [64] =
      '{6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

   // raster position -> zigzag index
   localparam logic [5:0] SCAN_INDEX [64] =
      '{6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
        6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
        6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
        6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
        6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
        6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
        6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
        6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63};

   function automatic logic is_short(input logic signed [LEVEL_WIDTH-1:0] v);
      return (v >= -9'sd4) && (v <= 9'sd3);
   endfunction

   function automatic logic is_medium(input logic signed [LEVEL_WIDTH-1:0] v);
      return (v >= -9'sd32) && (v <= 9'sd31);
   endfunction

endpackage

`default_nettype wire

/* sv/block_coefficient_encoder_core.sv */
// block_coefficient_encoder_core: quantise, zigzag and run-length code 8x8 blocks
// depends on bce_pkg, bce_ram, bce_queue, bce_front and bce_back
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_ready  req_type  (kind, coefficient)
//   rsp_         out   rsp_valid/rsp_ready  rsp_type  (word, last)
//   csr_         in    csr_write_enable     csr_write_data (table select)
//
// coefficients load one per cycle while req_ready is high
// a queued flush is popped in the idle state once the output is free; the coding pass
// pops the command, primes the read-out window, then codes each value, zero and run in
// scan order, then a finish step sends any held word; its pace is set by the single ram
// read port and the one-code-per-cycle packer, which waits while the output is busy
// two store banks let the next block load while the previous one is coded
// reset is synchronous and clears control state only; the store needs no clearing
// a stalled rsp_ holds the packer, and req_ stalls once both banks are busy or the queue is full
`default_nettype none

module block_coefficient_encoder_core import bce_pkg::*; #(
   parameter int COEFF_FRACTION_BITS = 4,
   parameter int QUEUE_DEPTH         = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   // store write side (front) and read side (back)
   logic                   ram_we;
   logic [6:0]             ram_waddr;
   logic [LEVEL_WIDTH-1:0] ram_wdata;
   logic [6:0]             ram_raddr;
   logic [LEVEL_WIDTH-1:0] ram_rdata;

   // command queue
   logic    push, pop, queue_full, queue_empty;
   cmd_type push_cmd, head_cmd;

   // block completion back to the load side
   logic       block_done;
   logic [1:0] pending;

   bce_front #(
      .FRACTION_BITS (COEFF_FRACTION_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req               (req),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .queue_full        (queue_full),
      .block_done        (block_done),
      .ram_write_enable  (ram_we),
      .ram_write_address (ram_waddr),
      .ram_write_data    (ram_wdata),
      .push              (push),
      .cmd               (push_cmd),
      .pending           (pending)
   );

   // two banks of one block each
   bce_ram #(
      .WIDTH (LEVEL_WIDTH),
      .DEPTH (BANKS * BLOCK_SIZE)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   bce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (head_cmd),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   bce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .head             (head_cmd),
      .queue_pop        (pop),
      .ram_read_address (ram_raddr),
      .ram_read_data    (ram_rdata),
      .block_done       (block_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp)
   );

`ifndef SYNTHESIS
   // never push a command into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("command pushed into full queue");

   // a block can only finish if one was handed over
   assert property (@(posedge clock) disable iff (reset) block_done |-> (pending != 2'd0))
      else $error("block finished with none pending");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !queue_empty)
      else $error("command popped from empty queue");

   // output register is empty straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire

/* sv/bce_ram.sv */
// bce_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bce_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

`default_nettype wire

/* sv/bce_queue.sv */
// bce_queue: short command fifo between the load side and the coding side
// depends on bce_pkg for cmd_type
`default_nettype none

module bce_queue import bce_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         full,
   output logic         empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/bce_front.sv */
// bce_front: accepts words, quantises coefficients into the block store, queues commands
// depends on bce_pkg; drives the write port of bce_ram and the push side of bce_queue
`default_nettype none

module bce_front import bce_pkg::*; #(
   parameter int FRACTION_BITS = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   input  wire logic    queue_full,
   input  wire logic    block_done,
   output logic         ram_write_enable,
   output logic [6:0]   ram_write_address,
   output logic [LEVEL_WIDTH-1:0] ram_write_data,
   output logic         push,
   output cmd_type      cmd,
   output logic [1:0]   pending
);

   logic        table_sel_ff;
   logic [5:0]  pos_ff, pos_in;
   logic        bank_ff, bank_in;
   logic        any_nz_ff, any_nz_in;
   logic [5:0]  last_nz_ff, last_nz_in;
   logic [1:0]  pending_ff, pending_in;

   logic        accept, accept_coeff;
   logic [19:0] raw, mag;
   logic        neg;
   logic [3:0]  tab_idx, shift;
   logic [2:0]  step_log2;
   logic [20:0] half, total, r;
   logic [LEVEL_WIDTH-1:0] level;
   logic        base_any;
   logic [5:0]  base_last, zz;

   assign req_ready    = !queue_full && (pending_ff < 2'd2);
   assign accept       = req_valid && req_ready;
   assign accept_coeff = accept && (req.kind == KIND_COEFF);
   assign pending      = pending_ff;

   // quantiser: round half away from zero by a power-of-two step, then clip
   always_comb begin
      raw       = req.coefficient;
      neg       = raw[19];
      mag       = neg ? (~raw + 20'd1) : raw;
      tab_idx   = {1'b0, pos_ff[5:3]} + {1'b0, pos_ff[2:0]};
      step_log2 = table_sel_ff ? STEP_FINE_LOG2[tab_idx] : STEP_COARSE_LOG2[tab_idx];
      shift     = {1'b0, step_log2} + 4'(FRACTION_BITS);
      half      = 21'd1 << (shift - 4'd1);
      total     = {1'b0, mag} + half;
      r         = total >> shift;
      if (neg) begin
         level = (r > 21'd256) ? 9'h100 : 9'(~r + 21'd1);
      end else begin
         level = (r > 21'd255) ? 9'd255 : r[8:0];
      end
   end

   // last nonzero position in scan order, for the end-of-block marker
   always_comb begin
      zz         = SCAN_INDEX[pos_ff];
      base_any   = (pos_ff == 6'd0) ? 1'b0 : any_nz_ff;
      base_last  = (pos_ff == 6'd0) ? 6'd0 : last_nz_ff;
      any_nz_in  = base_any;
      last_nz_in = base_last;
      if (level != '0) begin
         any_nz_in = 1'b1;
         if (!base_any || (zz > base_last)) begin
            last_nz_in = zz;
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      bank_in = bank_ff;
      if (accept_coeff) begin
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd63) begin
            bank_in = !bank_ff;
         end
      end
      pending_in = pending_ff;
      if ((push && (req.kind == KIND_COEFF)) && !block_done) begin
         pending_in = pending_ff + 2'd1;
      end else if (block_done && !(push && (req.kind == KIND_COEFF))) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   assign ram_write_enable  = accept_coeff;
   assign ram_write_address = {bank_ff, pos_ff};
   assign ram_write_data    = level;

   assign push        = accept && ((req.kind == KIND_FLUSH) || (pos_ff == 6'd63));
   assign cmd.kind    = req.kind;
   assign cmd.bank    = bank_ff;
   assign cmd.any_nz  = any_nz_in;
   assign cmd.last_nz = last_nz_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_sel_ff <= 1'b0;
         pos_ff       <= '0;
         bank_ff      <= 1'b0;
         pending_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            table_sel_ff <= csr_write_data;
         end
         pos_ff     <= pos_in;
         bank_ff    <= bank_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_coeff) begin
         any_nz_ff  <= any_nz_in;
         last_nz_ff <= last_nz_in;
      end
   end

endmodule

`default_nettype wire

/* sv/bce_back.sv */
// bce_back: zigzag read-out, run-length coding and 16-bit word packing
// depends on bce_pkg; reads bce_ram and pops bce_queue
`default_nettype none

module bce_back import bce_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    queue_empty,
   input  wire cmd_type head,
   output logic         queue_pop,
   output logic [6:0]   ram_read_address,
   input  wire logic [LEVEL_WIDTH-1:0] ram_read_data,
   output logic         block_done,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CODE   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type  state_ff, state_in;

   logic signed [LEVEL_WIDTH-1:0] win_ff [4];
   logic signed [LEVEL_WIDTH-1:0] win_in [4];
   logic [2:0]  wcnt_ff, wcnt_in;
   logic        rd_pend_ff;
   logic [6:0]  ra_ff, ra_in;
   logic [6:0]  k_ff, k_in;
   logic [2:0]  run_ff, run_in;
   logic        bank_ff, bank_in;
   logic        any_nz_ff, any_nz_in;
   logic [5:0]  last_nz_ff, last_nz_in;

   logic [15:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] hold_ff, hold_in;
   logic        hold_valid_ff, hold_valid_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic        out_free, go, issue, trailing, pair_ok;
   logic [2:0]  need, wnext;
   logic [1:0]  cons;
   logic [1:0]  slot;
   logic        tok_valid;
   logic [12:0] tok;
   logic [3:0]  tok_len;
   logic [28:0] val;
   logic [4:0]  total;
   logic [15:0] packed_word;
   logic signed [LEVEL_WIDTH-1:0] cur, n1, n2;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign cur = win_ff[0];
   assign n1  = win_ff[1];
   assign n2  = win_ff[2];
   assign ram_read_address = {bank_ff, SCAN_ORDER[ra_ff[5:0]]};

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      ra_in         = ra_ff;
      run_in        = run_ff;
      bank_in       = bank_ff;
      any_nz_in     = any_nz_ff;
      last_nz_in    = last_nz_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      queue_pop     = 1'b0;
      block_done    = 1'b0;
      cons          = 2'd0;
      tok_valid     = 1'b0;
      tok           = '0;
      tok_len       = '0;
      issue         = 1'b0;

      need     = (k_ff >= 7'd62) ? 3'(7'd64 - k_ff) : 3'd3;
      go       = (wcnt_ff >= need) && out_free;
      trailing = !any_nz_ff || (k_ff[5:0] > last_nz_ff);
      pair_ok  = (k_ff < 7'd63) && is_short(n1)
                 && !((n1 == '0) && (k_ff < 7'd62) && (n2 == '0));

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               if (head.kind == KIND_FLUSH) begin
                  if (out_free) begin
                     queue_pop = 1'b1;
                     if (cnt_ff != '0) begin
                        out_in.word  = 16'({16'd0, buf_ff} << (5'd16 - {1'b0, cnt_ff}));
                        out_in.last  = 1'b1;
                        out_valid_in = 1'b1;
                        buf_in       = '0;
                        cnt_in       = '0;
                     end
                  end
               end else begin
                  queue_pop  = 1'b1;
                  bank_in    = head.bank;
                  any_nz_in  = head.any_nz;
                  last_nz_in = head.last_nz;
                  k_in       = '0;
                  ra_in      = '0;
                  run_in     = '0;
                  state_in   = ST_CODE;
               end
            end
         end
         ST_CODE: begin
            if (go) begin
               if (cur == '0) begin
                  if (trailing) begin
                     // end of block, pending run dropped
                     tok_valid = 1'b1;
                     tok       = 13'(4'b1010);
                     tok_len   = 4'd4;
                     state_in  = ST_FINISH;
                  end else begin
                     cons = 2'd1;
                     if (run_ff == 3'd7) begin
                        tok_valid = 1'b1;
                        tok       = 13'(5'b11000);
                        tok_len   = 4'd5;
                        run_in    = '0;
                     end else begin
                        run_in = run_ff + 3'd1;
                     end
                  end
               end else if (run_ff != '0) begin
                  tok_valid = 1'b1;
                  tok       = 13'({2'b11, run_ff});
                  tok_len   = 4'd5;
                  run_in    = '0;
               end else if (is_short(cur)) begin
                  tok_valid = 1'b1;
                  if (pair_ok) begin
                     tok     = 13'({2'b00, cur[2:0], n1[2:0]});
                     tok_len = 4'd8;
                     cons    = 2'd2;
                  end else begin
                     tok     = 13'({2'b01, cur[2:0]});
                     tok_len = 4'd5;
                     cons    = 2'd1;
                  end
               end else if (is_medium(cur)) begin
                  tok_valid = 1'b1;
                  tok       = 13'({3'b100, cur[5:0]});
                  tok_len   = 4'd9;
                  cons      = 2'd1;
               end else begin
                  tok_valid = 1'b1;
                  tok       = {4'b1011, cur};
                  tok_len   = 4'd13;
                  cons      = 2'd1;
               end
               k_in = k_ff + {5'd0, cons};
               if (k_in == 7'd64) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!hold_valid_ff) begin
               block_done = 1'b1;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               out_in.word   = hold_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               block_done    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // bit packer, one code per cycle while the output is free, at most one word completes
      val         = ({13'd0, buf_ff} << tok_len) | {16'd0, tok};
      total       = {1'b0, cnt_ff} + {1'b0, tok_len};
      packed_word = 16'(val >> (total - 5'd16));
      if (tok_valid) begin
         buf_in = val[15:0];
         if (total >= 5'd16) begin
            cnt_in = 4'(total - 5'd16);
            if (hold_valid_ff) begin
               out_in.word  = hold_ff;
               out_in.last  = 1'b0;
               out_valid_in = 1'b1;
            end
            hold_in       = packed_word;
            hold_valid_in = 1'b1;
         end else begin
            cnt_in = total[3:0];
         end
      end

      // look-ahead window refill
      for (int i = 0; i < 4; i++) begin
         win_in[i] = ((i + int'(cons)) < 4) ? win_ff[(i + int'(cons)) % 4] : win_ff[i];
      end
      slot  = 2'(wcnt_ff - {1'b0, cons});
      wnext = wcnt_ff - {1'b0, cons} + {2'd0, rd_pend_ff};
      if (rd_pend_ff) begin
         win_in[slot] = ram_read_data;
      end
      if (state_ff != ST_CODE) begin
         wnext = '0;
      end
      if ((state_ff == ST_CODE) && (ra_ff < 7'd64) && (wnext <= 3'd3)) begin
         issue = 1'b1;
         ra_in = ra_ff + 7'd1;
      end
      wcnt_in = wnext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wcnt_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         buf_ff        <= '0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wcnt_ff       <= wcnt_in;
         rd_pend_ff    <= issue;
         buf_ff        <= buf_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff     <= win_in;
      ra_ff      <= ra_in;
      k_ff       <= k_in;
      run_ff     <= run_in;
      bank_ff    <= bank_in;
      any_nz_ff  <= any_nz_in;
      last_nz_ff <= last_nz_in;
      hold_ff    <= hold_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

/* test/tb_block_coefficient_encoder_core.sv */
// testbench for block_coefficient_encoder_core: drives coefficient blocks and flushes,
// predicts the packed bitstream words and compares them word by word
// depends on bce_pkg and the block_coefficient_encoder_core rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_block_coefficient_encoder_core;
   import bce_pkg::*;

   localparam int IDLE_LIMIT   = 20000;  // cycles with no word accepted on either side
   localparam int SETTLE_CYCLES = 120;   // coding pass of a block plus priming, with margin

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;

   always #5 clock = ~clock;

   block_coefficient_encoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req              (req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // predictor state: own copy of the block store, load position and packer
   // ---------------------------------------------------------------------
   logic                          table_fine;
   logic signed [LEVEL_WIDTH-1:0] level_store [BLOCK_SIZE];
   logic [5:0]                    load_pos;
   logic [15:0]                   pack_bits;
   logic [3:0]                    pack_fill;
   logic [2:0]                    run_length;

   rsp_type coded_words [$];   // words still owed by the block, oldest first

   int error_count = 0;
   int idle_pct    = 0;        // chance the sender idles before a word
   int stall_pct   = 0;        // chance the receiver holds off in a cycle

   // step exponent for a raster position under the current table
   function automatic int step_log2(input logic [5:0] pos);
      int diag;
      diag = pos[5:3] + pos[2:0];
      return table_fine ? STEP_FINE_LOG2[diag] : STEP_COARSE_LOG2[diag];
   endfunction

   // divide by the step, round half away from zero, clip to the level range
   function automatic logic signed [LEVEL_WIDTH-1:0] quantise(
      input logic [COEFF_WIDTH-1:0] raw, input logic [5:0] pos);
      logic        neg;
      int unsigned mag, d, r;
      neg = raw[COEFF_WIDTH-1];
      mag = neg ? (32'h100000 - raw) : raw;
      d   = 1 << (step_log2(pos) + 4);
      r   = (2 * mag + d) / (2 * d);
      if (neg) return (r > 256) ? -9'sd256 : -$signed(r[8:0]);
      return (r > 255) ? 9'sd255 : $signed(r[8:0]);
   endfunction

   function automatic void put_bits(input int unsigned data, input int len);
      rsp_type w;
      for (int i = len - 1; i >= 0; i--) begin
         pack_bits = {pack_bits[14:0], data[i]};
         pack_fill = pack_fill + 4'd1;
         if (pack_fill == 4'd0) begin
            w.word = pack_bits;
            w.last = 1'b0;
            coded_words.push_back(w);
         end
      end
   endfunction

   function automatic logic level_short(input logic signed [LEVEL_WIDTH-1:0] v);
      return (v < 4) && (v >= -4);
   endfunction

   function automatic logic signed [LEVEL_WIDTH-1:0] zz(input int k);
      return level_store[SCAN_ORDER[k]];
   endfunction

   // zigzag scan of the stored block into run-length codes
   function automatic void code_stored_block();
      int j;
      logic signed [LEVEL_WIDTH-1:0] v, nx;
      run_length = 3'd0;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
         v = zz(k);
         if (v == 0) begin
            for (j = k + 1; j < BLOCK_SIZE; j++)
               if (zz(j) != 0) break;
            if (j == BLOCK_SIZE) begin
               put_bits(4'b1010, 4);   // end of block, pending run dropped
               break;
            end else if (run_length == 3'd7) begin
               run_length = 3'd0;      // eight zeros coded as count 000
               put_bits(2'b11, 2);
               put_bits(0, 3);
            end else begin
               run_length++;
            end
            continue;
         end
         if (run_length != 0) begin
            put_bits(2'b11, 2);
            put_bits(run_length, 3);
            run_length = 3'd0;
         end
         if (level_short(v)) begin
            nx = (k + 1 < BLOCK_SIZE) ? zz(k + 1) : '0;
            if (k + 1 < BLOCK_SIZE && level_short(nx) &&
                !(nx == 0 && k + 2 < BLOCK_SIZE && zz(k + 2) == 0)) begin
               put_bits(0, 2);
               put_bits(v[2:0], 3);
               k++;
               put_bits(nx[2:0], 3);
            end else begin
               put_bits(2'b01, 2);
               put_bits(v[2:0], 3);
            end
         end else if (v < 32 && v >= -32) begin
            put_bits(3'b100, 3);
            put_bits(v[5:0], 6);
         end else begin
            put_bits(4'b1011, 4);
            put_bits(v[8:0], 9);
         end
      end
   endfunction

   // work out the words one accepted item owes, marking the final one
   function automatic void predict_item(input req_type item);
      int prior_count;
      rsp_type w;
      prior_count = coded_words.size();
      if (item.kind == KIND_FLUSH) begin
         if (pack_fill != 0) begin
            w.word = pack_bits << (16 - pack_fill);
            w.last = 1'b0;
            coded_words.push_back(w);
            pack_bits = '0;
            pack_fill = '0;
         end
      end else begin
         level_store[load_pos] = quantise(item.coefficient, load_pos);
         if (load_pos == 6'd63) code_stored_block();
         load_pos = load_pos + 6'd1;
      end
      if (coded_words.size() > prior_count) coded_words[$].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // present one word on req_ and hold it until it is taken; called at a falling edge
   task automatic send_word(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (!req_ready);
      predict_item(item);
      @(negedge clock);
   endtask

   task automatic send_coeff(input int value);
      req_type item;
      item.kind        = KIND_COEFF;
      item.coefficient = value[COEFF_WIDTH-1:0];
      send_word(item);
   endtask

   task automatic send_flush();
      req_type item;
      item.kind        = KIND_FLUSH;
      item.coefficient = 20'($urandom);   // ignored by the block
      send_word(item);
   endtask

   // lower valid and wait for every owed word, then let the coder settle
   task automatic drain();
      req_valid <= 1'b0;
      while (coded_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_table(input logic fine);
      csr_write_enable <= 1'b1;
      csr_write_data   <= fine;
      @(negedge clock);
      table_fine = fine;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'($urandom);
   endtask

   task automatic set_pace(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   // random coefficient aimed at a level class for the next position
   function automatic int pick_coeff(input int profile);
      int unit, cls;
      unit = 1 << (step_log2(load_pos) + 4);
      cls  = $urandom_range(99);
      // sparse blocks lean on zeros and shorts, dense ones on medium and long
      if (profile == 0) cls = (cls < 60) ? 0 : (cls < 85) ? 1 : (cls < 95) ? 2 : 3;
      else if (profile == 1) cls = (cls < 25) ? 0 : (cls < 60) ? 1 : (cls < 85) ? 2 : 3;
      else cls = (cls < 10) ? 0 : (cls < 30) ? 1 : (cls < 60) ? 2 : 3;
      case (cls)
         0: return $signed($urandom_range(unit - 1)) - unit / 2;
         1: return $signed($urandom_range(9 * unit)) - 9 * unit / 2;
         2: return $signed($urandom_range(65 * unit)) - 65 * unit / 2;
         default: return $signed({{12{1'b0}}, 20'($urandom)} << 12) >>> 12;
      endcase
   endfunction

   task automatic random_block(input int profile);
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         if ($urandom_range(99) < 4) send_flush();   // flush mid-block leaves the load alone
         send_coeff(pick_coeff(profile));
      end
      if ($urandom_range(99) < 40) send_flush();
   endtask

   // ---------------------------------------------------------------------
   // named tests
   // ---------------------------------------------------------------------

   // flush on an empty packer, then a hand-built block with every code type
   task automatic test_directed_codes();
      set_pace(0, 0);
      send_flush();                       // nothing pending, no word
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         case (SCAN_INDEX[i])
            0:  send_coeff(524287);       // largest input, clips to 255
            1:  send_coeff(-524288);      // smallest input, clips to -256
            2:  send_coeff(3 * 64);       // short pair
            3:  send_coeff(-4 * 128);
            4:  send_coeff(2 * 128 + 64); // exact half rounds away from zero
            5:  send_coeff(0);            // short then zero, zero: no pair
            6:  send_coeff(0);
            7:  send_coeff(-31 * 128);    // medium after a run of two
            17: send_coeff(40 * 256);     // long after a run of nine (8 coded as 000)
            20: send_coeff(-(256 + 128)); // negative half rounds to -2
            default: send_coeff(0);       // trailing zeros end the block
         endcase
      end
      send_flush();
      send_flush();                       // second flush finds nothing pending
      drain();
   endtask

   // fine table with the sender idling, then the table changed part way through
   // the block load and the rest sent with both sides pausing
   task automatic test_table_select();
      set_pace(52, 0);
      write_table(1'b1);
      for (int i = 0; i < 32; i++) send_coeff(pick_coeff(1));
      drain();
      write_table(1'b0);
      set_pace(19, 19);
      for (int i = 32; i < BLOCK_SIZE; i++) send_coeff(pick_coeff(1));
      send_flush();
      drain();
   endtask

   // a random block with the receiver stalling, on a random table
   task automatic test_random_traffic();
      write_table(1'($urandom_range(1)));
      set_pace(0, 52);
      random_block($urandom_range(2));
      drain();   // sender waits for every owed word before moving on
   endtask

   // ---------------------------------------------------------------------
   // receiver pacing, result checking and the watchdog
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (coded_words.size() == 0) begin
            $error("unexpected word %h last %b", rsp.word, rsp.last);
            error_count++;
         end else begin
            want = coded_words.pop_front();
            if (rsp.word !== want.word) begin
               $error("word: expected %h got %h", want.word, rsp.word);
               error_count++;
            end
            if (rsp.last !== want.last) begin
               $error("last: expected %b got %b", want.last, rsp.last);
               error_count++;
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      table_fine = 1'b0;
      load_pos   = '0;
      pack_bits  = '0;
      pack_fill  = '0;
      run_length = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_codes();
      test_table_select();
      test_random_traffic();
      drain();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
